FILE: rtl/csks_pkg.sv
// Shared types and constants for the cyclic shift KMP search block.
`default_nettype none

package csks_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_TQ    = 9'b000000010,
        S_TK    = 9'b000000100,
        S_TCMP  = 9'b000001000,
        S_TFAIL = 9'b000010000,
        S_SI    = 9'b000100000,
        S_SK    = 9'b001000000,
        S_SCMP  = 9'b010000000,
        S_SFAIL = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/csks_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module csks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/cyclic_shift_kmp_search.sv
// Top level: cyclic rotation check of a pattern against a text by KMP search.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | start & !busy          | i_pattern_byte, i_text_byte, i_is_last
//  result   | o_strobe (one cycle)   | o_found, o_shift, o_overflow
//
// A beat without is_last is stored, or sets overflow once full; busy stays low.
// The beat with is_last raises busy. The prefix table then steps through TQ,
// TK and TCMP per pattern position plus TFAIL and TCMP per failure jump, the
// search through SI, SK and SCMP per text character plus SFAIL and SCMP per jump.
// The single registered read port of each store sets these steps.
// Reset is synchronous, active low; the stores need no clearing pass.
// The result shows for one cycle with busy already low; it cannot be stalled.
`default_nettype none

module cyclic_shift_kmp_search #(
    parameter int MAX_LEN = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [csks_pkg::BYTE_W-1:0] i_pattern_byte,
    input  wire logic [csks_pkg::BYTE_W-1:0] i_text_byte,
    input  wire logic                        i_is_last,
    output logic                             o_strobe,
    output logic                             o_found,
    output logic [csks_pkg::BYTE_W-1:0]      o_shift,
    output logic                             o_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int BW = csks_pkg::BYTE_W;

    csks_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_q, n_q;
    logic [AW-1:0] r_k, n_k;
    logic [CW-1:0] r_m, n_m;
    logic [AW-1:0] r_j, n_j;
    logic          r_pass2, n_pass2;
    logic [BW-1:0] r_c, n_c;
    logic          r_strobe, n_strobe;
    logic          r_found, n_found;
    logic [BW-1:0] r_shift, n_shift;
    logic          r_ovf_out, n_ovf_out;

    logic          accept;
    logic          full;
    logic          load_we;
    logic [AW-1:0] pat_raddr;
    logic [BW-1:0] pat_rdata;
    logic [BW-1:0] txt_rdata;
    logic          fail_we;
    logic [AW-1:0] fail_waddr;
    logic [AW-1:0] fail_wdata;
    logic [AW-1:0] fail_raddr;
    logic [AW-1:0] fail_rdata;
    logic          pat_eq;
    logic [AW-1:0] k_next;
    logic [CW-1:0] m_next;
    logic          last_step;
    logic [AW-1:0] j_inc;
    logic [AW+BW-1:0] shift_wide;

    assign accept  = start && !busy;
    assign full    = (r_count == CW'(MAX_LEN));
    assign load_we = accept && !full;
    assign pat_eq  = (pat_rdata == r_c);
    assign k_next  = pat_eq ? r_k + AW'(1) : r_k;
    assign m_next  = pat_eq ? r_m + CW'(1) : r_m;
    assign j_inc   = r_j + AW'(1);
    assign shift_wide = {{BW{1'b0}}, j_inc};
    assign last_step  = r_pass2 ? (CW'(r_j) + CW'(2) == r_count) : (r_count == CW'(1));
    // entry 0 of the prefix table is zero; it is written while pairs load
    assign fail_we    = load_we ||
                        ((r_state == csks_pkg::S_TCMP) && !((r_k != '0) && !pat_eq));
    assign fail_waddr = load_we ? '0 : r_q;
    assign fail_wdata = load_we ? '0 : k_next;

    always_comb begin
        pat_raddr  = r_q;
        fail_raddr = '0;
        unique case (r_state)
            csks_pkg::S_TK:    pat_raddr = r_k;
            csks_pkg::S_TFAIL: pat_raddr = fail_rdata;
            csks_pkg::S_SK:    pat_raddr = r_m[AW-1:0];
            csks_pkg::S_SFAIL: pat_raddr = fail_rdata;
            csks_pkg::S_TCMP:  fail_raddr = r_k - AW'(1);
            csks_pkg::S_SCMP:  fail_raddr = r_m[AW-1:0] - AW'(1);
            default:           pat_raddr = r_q;
        endcase
    end

    csks_ram #(.WIDTH(BW), .DEPTH(MAX_LEN)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_pattern_byte),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    csks_ram #(.WIDTH(BW), .DEPTH(MAX_LEN)) u_txt_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_text_byte),
        .i_raddr (r_j),
        .o_rdata (txt_rdata)
    );

    csks_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (fail_we),
        .i_waddr (fail_waddr),
        .i_wdata (fail_wdata),
        .i_raddr (fail_raddr),
        .o_rdata (fail_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_q       = r_q;
        n_k       = r_k;
        n_m       = r_m;
        n_j       = r_j;
        n_pass2   = r_pass2;
        n_c       = r_c;
        n_strobe  = 1'b0;
        n_found   = r_found;
        n_shift   = r_shift;
        n_ovf_out = r_ovf_out;
        unique case (r_state)
            csks_pkg::S_LOAD: begin
                if (accept) begin
                    if (!full) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_q     = AW'(1);
                        n_k     = '0;
                        n_m     = '0;
                        n_j     = '0;
                        n_pass2 = 1'b0;
                        n_state = (n_count == CW'(1)) ? csks_pkg::S_SI : csks_pkg::S_TQ;
                    end
                end
            end
            csks_pkg::S_TQ: begin
                n_state = csks_pkg::S_TK;
            end
            csks_pkg::S_TK: begin
                n_c     = pat_rdata;
                n_state = csks_pkg::S_TCMP;
            end
            csks_pkg::S_TCMP: begin
                if ((r_k != '0) && !pat_eq) begin
                    n_state = csks_pkg::S_TFAIL;
                end else begin
                    n_k = k_next;
                    n_q = r_q + AW'(1);
                    if (CW'(r_q) + CW'(1) == r_count) begin
                        n_state = csks_pkg::S_SI;
                    end else begin
                        n_state = csks_pkg::S_TQ;
                    end
                end
            end
            csks_pkg::S_TFAIL: begin
                n_k     = fail_rdata;
                n_state = csks_pkg::S_TCMP;
            end
            csks_pkg::S_SI: begin
                n_state = csks_pkg::S_SK;
            end
            csks_pkg::S_SK: begin
                n_c     = txt_rdata;
                n_state = csks_pkg::S_SCMP;
            end
            csks_pkg::S_SCMP: begin
                if ((r_m != '0) && !pat_eq) begin
                    n_state = csks_pkg::S_SFAIL;
                end else begin
                    n_m = m_next;
                    if (m_next == r_count || last_step) begin
                        n_strobe  = 1'b1;
                        n_found   = (m_next == r_count);
                        n_shift   = (m_next == r_count && r_pass2) ? shift_wide[BW-1:0] : '0;
                        n_ovf_out = r_ovf;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_state   = csks_pkg::S_LOAD;
                    end else begin
                        if (!r_pass2 && (CW'(r_j) + CW'(1) == r_count)) begin
                            n_j     = '0;
                            n_pass2 = 1'b1;
                        end else begin
                            n_j = j_inc;
                        end
                        n_state = csks_pkg::S_SI;
                    end
                end
            end
            csks_pkg::S_SFAIL: begin
                n_m     = CW'(fail_rdata);
                n_state = csks_pkg::S_SCMP;
            end
            default: begin
                n_state = csks_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= csks_pkg::S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_k       <= n_k;
        r_m       <= n_m;
        r_j       <= n_j;
        r_pass2   <= n_pass2;
        r_c       <= n_c;
        r_found   <= n_found;
        r_shift   <= n_shift;
        r_ovf_out <= n_ovf_out;
    end

    assign busy       = (r_state != csks_pkg::S_LOAD);
    assign o_strobe   = r_strobe;
    assign o_found    = r_found;
    assign o_shift    = r_shift;
    assign o_overflow = r_ovf_out;

endmodule

`default_nettype wire

FILE: rtl/csks_chk.sv
// Port-level checker for the cyclic shift KMP search block, with its bind.
`default_nettype none

module csks_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        i_is_last,
    input wire logic                        o_strobe,
    input wire logic                        o_found,
    input wire logic [csks_pkg::BYTE_W-1:0] o_shift
);

    // result follows a busy search
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a preceding search");

    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy while result is shown");

    a_shift_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_shift == '0))
        else $error("nonzero shift on a miss");

    a_load_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_is_last) |=> (!busy && !o_strobe))
        else $error("non-final beat did not keep the block ready");

    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_is_last) |=> busy)
        else $error("final beat did not start the search");

endmodule

bind cyclic_shift_kmp_search csks_chk u_csks_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_is_last (i_is_last),
    .o_strobe  (o_strobe),
    .o_found   (o_found),
    .o_shift   (o_shift)
);

`default_nettype wire

FILE: test/tb_cyclic_shift_kmp_search.sv
// Testbench for the cyclic shift KMP search block: directed table, then random string pairs.
`default_nettype none

module tb_cyclic_shift_kmp_search;

    localparam int MAX_LEN     = 256;
    localparam int BUF_LEN     = 320;
    localparam int ITEM_GOAL   = 1350;
    localparam int CALM_AFTER  = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_ROWS      = 23;

    typedef logic [csks_pkg::BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic  found;
        t_byte shift;
        logic  overflow;
    } t_verdict;

    typedef struct packed {
        t_byte pat;
        t_byte txt;
        logic  last;
        logic  typed;
        logic  f;
        t_byte s;
        logic  o;
    } t_row;

    logic  i_clk;
    logic  i_rst_n        = 1'b0;
    logic  start          = 1'b0;
    logic  busy;
    t_byte i_pattern_byte = '0;
    t_byte i_text_byte    = '0;
    logic  i_is_last      = 1'b0;
    logic  o_strobe;
    logic  o_found;
    t_byte o_shift;
    logic  o_overflow;

    cyclic_shift_kmp_search #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_pattern_byte(i_pattern_byte),
        .i_text_byte(i_text_byte),
        .i_is_last(i_is_last),
        .o_strobe(o_strobe),
        .o_found(o_found),
        .o_shift(o_shift),
        .o_overflow(o_overflow)
    );

    // pattern, text, last, typed, found, shift, overflow
    t_row script [0:N_ROWS-1] = '{
        '{8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
        '{8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
        '{8'h01, 8'hFE, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h42, 8'h41, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h43, 8'h42, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h41, 8'h43, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h01, 8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h02, 8'h03, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h41, 8'h41, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h41, 8'h42, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h41, 8'h41, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h42, 8'h41, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h55, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h55, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h55, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h55, 8'h55, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
        '{8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80, 8'h80, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
        '{8'h41, 8'h42, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h42, 8'h41, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h41, 8'h41, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    t_byte       pat_mem [MAX_LEN];
    t_byte       txt_mem [MAX_LEN];
    int unsigned fill_cnt = 0;
    logic        dropped  = 1'b0;

    t_byte       pat_buf [BUF_LEN];
    t_byte       txt_buf [BUF_LEN];

    t_verdict    verdict_q [$];
    int          items_sent = 0;
    int          fail_cnt   = 0;
    int          cycle_cnt  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // prefix table of the pattern, then a search over text followed by its own head
    function automatic t_verdict rotation_verdict(input int unsigned n);
        int unsigned fail_tbl [MAX_LEN];
        int unsigned k;
        int unsigned m;
        t_byte       c;
        t_verdict    v;
        v = '0;
        k = 0;
        fail_tbl[0] = 0;
        for (int unsigned q = 1; q < n; q++) begin
            while (k > 0 && pat_mem[k] != pat_mem[q])
                k = fail_tbl[k-1];
            if (pat_mem[k] == pat_mem[q])
                k++;
            fail_tbl[q] = k;
        end
        m = 0;
        for (int unsigned i = 0; i < 2*n - 1 && !v.found; i++) begin
            c = (i < n) ? txt_mem[i] : txt_mem[i-n];
            while (m > 0 && pat_mem[m] != c)
                m = fail_tbl[m-1];
            if (pat_mem[m] == c)
                m++;
            if (m == n) begin
                v.found = 1'b1;
                v.shift = t_byte'(i + 1 - n);
            end
        end
        return v;
    endfunction

    task automatic send_beat(input t_byte p, input t_byte t, input logic last,
                             input logic idle_ok, input logic typed, input t_verdict typed_v);
        int       gap;
        t_verdict v;
        if (idle_ok && items_sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_pattern_byte <= p;
        i_text_byte    <= t;
        i_is_last      <= last;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        items_sent++;
        if (fill_cnt < MAX_LEN) begin
            pat_mem[fill_cnt] = p;
            txt_mem[fill_cnt] = t;
            fill_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            v = rotation_verdict(fill_cnt);
            v.overflow = dropped;
            verdict_q.push_back(typed ? typed_v : v);
            fill_cnt = 0;
            dropped  = 1'b0;
        end
    endtask

    task automatic send_pairs(input int n, input logic idle_ok);
        for (int i = 0; i < n; i++)
            send_beat(pat_buf[i], txt_buf[i], i == n - 1, idle_ok, 1'b0, '0);
    endtask

    // alphabet size 0 gives a run of distinct bytes
    task automatic fill_rotation(input int n, input int s, input int alph);
        t_byte base;
        base = t_byte'($urandom_range(0, 255));
        for (int i = 0; i < n; i++)
            txt_buf[i] = (alph == 0) ? t_byte'(base + i)
                                     : t_byte'(base + $urandom_range(0, alph - 1));
        for (int k = 0; k < n; k++)
            pat_buf[k] = txt_buf[(s + k) % n];
    endtask

    initial begin
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_beat(script[r].pat, script[r].txt, script[r].last, 1'b1, script[r].typed,
                      t_verdict'{script[r].f, script[r].s, script[r].o});

        // full length, largest shift
        fill_rotation(MAX_LEN, MAX_LEN - 1, 0);
        send_pairs(MAX_LEN, 1'b1);

        // two pairs past the store, the last one among them
        fill_rotation(MAX_LEN, $urandom_range(0, MAX_LEN - 1), 3);
        for (int i = MAX_LEN; i < MAX_LEN + 2; i++) begin
            pat_buf[i] = t_byte'($urandom);
            txt_buf[i] = t_byte'($urandom);
        end
        send_pairs(MAX_LEN + 2, 1'b1);

        while (items_sent < ITEM_GOAL) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            fill_rotation(n, $urandom_range(0, n - 1), $urandom_range(0, 4));
            case ($urandom_range(0, 3))
                2: begin
                    pat_buf[$urandom_range(0, n - 1)] ^= t_byte'($urandom_range(1, 255));
                end
                3: begin
                    for (int i = 0; i < n; i++)
                        pat_buf[i] = txt_buf[$urandom_range(0, n - 1)];
                end
                default: ;
            endcase
            send_pairs(n, $urandom_range(0, 2) != 0);
        end

        start <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (verdict_q.size() == 0) begin
                $error("result beat with none expected: found=%0b shift=%0d overflow=%0b",
                       o_found, o_shift, o_overflow);
                fail_cnt++;
            end else begin
                want = verdict_q.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_found);
                    fail_cnt++;
                end
                if (o_shift !== want.shift) begin
                    $error("shift: expected %0d, got %0d", want.shift, o_shift);
                    fail_cnt++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, o_overflow);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

`default_nettype wire
